// ===== src/jsr_pkg.sv =====
// jsr_pkg: shared types and constants for the jpeg scan restuffer
// marker byte values, parse phase codes and the per-request result batch
// no dependencies
package jsr_pkg;

  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_SOS = 8'hDA;
  localparam logic [7:0] BYTE_EOI = 8'hD9;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [4:0] RST_PREFIX = 5'b11010;

  localparam int MaxItems = 6;
  localparam int ItemIdxW = 3;

  localparam logic [2:0] PH_HOLD = 3'd0;
  localparam logic [2:0] PH_SCAN = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_REST = 3'd4;
  localparam logic [2:0] PH_ENTROPY = 3'd5;
  localparam logic [2:0] PH_REJECT = 3'd6;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       status;
  } item_t;

  typedef struct packed {
    item_t [MaxItems-1:0] items;
    logic [ItemIdxW-1:0]  count;
  } batch_t;

endpackage

// ===== src/jsr_in_if.sv =====
// jsr_in_if: input byte channel of the restuffer
// valid/ready handshake with byte and frame-end flag, no dependencies
interface jsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

// ===== src/jsr_out_if.sv =====
// jsr_out_if: output byte channel of the restuffer
// valid/ready handshake with byte, frame-end flag and reject status
interface jsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       status;

  modport source(output valid, out_byte, out_last, status, input ready);
  modport sink(input valid, out_byte, out_last, status, output ready);
endinterface

// ===== src/jsr_front.sv =====
// jsr_front: accepts input bytes, tracks the frame parse state and builds
// the batch of result bytes each request causes
// depends on jsr_pkg and jsr_in_if
module jsr_front (
  input  logic            clk,
  input  logic            rst,
  jsr_in_if.sink          in_chan,
  input  logic            full,
  output logic            push,
  output jsr_pkg::batch_t batch
);
  import jsr_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [7:0]  hold [3];
  logic [1:0]  head_count, head_count_next;
  logic        prev_lead, prev_lead_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] header_left, header_left_next;
  logic        pending, pending_next;
  logic        discarding, discarding_next;
  logic        hold_we;
  logic        accept;

  function automatic batch_t add(batch_t b, logic [7:0] d, logic l, logic s);
    batch_t r;
    r = b;
    if (int'(b.count) < MaxItems) begin
      r.items[b.count] = '{data: d, last: l, status: s};
      r.count = b.count + ItemIdxW'(1);
    end
    return r;
  endfunction

  assign in_chan.ready = !full;
  assign accept = in_chan.valid && !full;

  always_comb begin
    logic [7:0]  b;
    logic        lst;
    logic        run;
    logic        done;
    logic [2:0]  ph;
    logic        pv;
    logic [15:0] len;
    batch_t      res;
    b = in_chan.in_byte;
    lst = in_chan.in_last;
    run = 1'b0;
    done = 1'b0;
    ph = phase;
    pv = prev_lead;
    len = {length_high, b};
    res = '0;
    phase_next = phase;
    head_count_next = head_count;
    prev_lead_next = prev_lead;
    length_high_next = length_high;
    header_left_next = header_left;
    pending_next = pending;
    discarding_next = discarding;
    hold_we = 1'b0;

    if (discarding) begin
      done = lst;
    end else if (phase == PH_REJECT) begin
      if (lst) begin
        res = add(res, BYTE_ZERO, 1'b1, 1'b1);
        done = 1'b1;
      end
    end else if (phase == PH_HOLD) begin
      if (head_count != 2'd3) begin
        if (lst) begin
          res = add(res, BYTE_ZERO, 1'b1, 1'b1);
          done = 1'b1;
        end else begin
          hold_we = 1'b1;
          head_count_next = head_count + 2'd1;
        end
      end else if (hold[0] != BYTE_FF || hold[1] != BYTE_SOI) begin
        if (lst) begin
          res = add(res, BYTE_ZERO, 1'b1, 1'b1);
          done = 1'b1;
        end else begin
          phase_next = PH_REJECT;
        end
      end else begin
        res = add(res, hold[0], 1'b0, 1'b0);
        res = add(res, hold[1], 1'b0, 1'b0);
        res = add(res, hold[2], 1'b0, 1'b0);
        ph = PH_SCAN;
        pv = (hold[2] == BYTE_FF);
        phase_next = PH_SCAN;
        run = 1'b1;
      end
    end else begin
      run = 1'b1;
    end

    if (run) begin
      case (ph)
        PH_SCAN: begin
          res = add(res, b, lst, 1'b0);
          if (pv && b == BYTE_SOS) phase_next = PH_LEN_HI;
          prev_lead_next = (b == BYTE_FF);
          done = lst;
        end
        PH_LEN_HI: begin
          res = add(res, b, lst, 1'b0);
          length_high_next = b;
          phase_next = PH_LEN_LO;
          prev_lead_next = (b == BYTE_FF);
          done = lst;
        end
        PH_LEN_LO: begin
          if (len < 16'd2) begin
            res = add(res, b, 1'b0, 1'b0);
            phase_next = PH_ENTROPY;
            prev_lead_next = 1'b0;
            if (lst) begin
              res = add(res, BYTE_FF, 1'b0, 1'b0);
              res = add(res, BYTE_EOI, 1'b1, 1'b0);
              done = 1'b1;
            end
          end else begin
            res = add(res, b, lst, 1'b0);
            header_left_next = len - 16'd2;
            phase_next = (len != 16'd2) ? PH_REST : PH_ENTROPY;
            prev_lead_next = (b == BYTE_FF);
            done = lst;
          end
        end
        PH_REST: begin
          res = add(res, b, lst, 1'b0);
          header_left_next = header_left - 16'd1;
          if (header_left == 16'd1) phase_next = PH_ENTROPY;
          prev_lead_next = (b == BYTE_FF);
          done = lst;
        end
        default: begin
          prev_lead_next = 1'b0;
          if (!pending) begin
            if (b == BYTE_FF) begin
              if (lst) begin
                res = add(res, BYTE_FF, 1'b0, 1'b0);
                res = add(res, BYTE_ZERO, 1'b0, 1'b0);
                done = 1'b1;
              end else begin
                pending_next = 1'b1;
              end
            end else if (lst && b == BYTE_EOI && pv) begin
              done = 1'b1;
            end else begin
              res = add(res, b, 1'b0, 1'b0);
              done = lst;
            end
          end else if (b == BYTE_EOI) begin
            if (lst) begin
              done = 1'b1;
            end else begin
              res = add(res, BYTE_FF, 1'b0, 1'b0);
              res = add(res, BYTE_FF, 1'b0, 1'b0);
              res = add(res, BYTE_EOI, 1'b1, 1'b0);
              pending_next = 1'b0;
              discarding_next = 1'b1;
            end
          end else if (b == BYTE_ZERO || b[7:3] == RST_PREFIX) begin
            res = add(res, BYTE_FF, 1'b0, 1'b0);
            res = add(res, b, 1'b0, 1'b0);
            pending_next = 1'b0;
            done = lst;
          end else if (b == BYTE_FF) begin
            res = add(res, BYTE_FF, 1'b0, 1'b0);
            res = add(res, BYTE_ZERO, 1'b0, 1'b0);
            if (lst) begin
              res = add(res, BYTE_FF, 1'b0, 1'b0);
              res = add(res, BYTE_ZERO, 1'b0, 1'b0);
              done = 1'b1;
            end
          end else begin
            res = add(res, BYTE_FF, 1'b0, 1'b0);
            res = add(res, BYTE_ZERO, 1'b0, 1'b0);
            res = add(res, b, 1'b0, 1'b0);
            pending_next = 1'b0;
            done = lst;
          end
          // entropy end of frame appends the end marker
          if (done) begin
            res = add(res, BYTE_FF, 1'b0, 1'b0);
            res = add(res, BYTE_EOI, 1'b1, 1'b0);
          end
        end
      endcase
    end

    if (done) begin
      phase_next = PH_HOLD;
      head_count_next = 2'd0;
      prev_lead_next = 1'b0;
      length_high_next = 8'd0;
      header_left_next = 16'd0;
      pending_next = 1'b0;
      discarding_next = 1'b0;
    end
    batch = res;
  end

  assign push = accept && (batch.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HOLD;
      head_count <= 2'd0;
      prev_lead <= 1'b0;
      length_high <= 8'd0;
      header_left <= 16'd0;
      pending <= 1'b0;
      discarding <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      head_count <= head_count_next;
      prev_lead <= prev_lead_next;
      length_high <= length_high_next;
      header_left <= header_left_next;
      pending <= pending_next;
      discarding <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_we) hold[head_count] <= in_chan.in_byte;
  end

endmodule

// ===== src/jsr_queue.sv =====
// jsr_queue: two-entry queue of result batches between front and back
// depends on jsr_pkg
module jsr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsr_pkg::batch_t wr_batch,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output jsr_pkg::batch_t rd_batch
);
  import jsr_pkg::*;

  batch_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rd_batch = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_batch;
  end

endmodule

// ===== src/jsr_back.sv =====
// jsr_back: walks the queued batch one result byte per cycle, while the
// output channel accepts, into the output register
// depends on jsr_pkg and jsr_out_if
module jsr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  jsr_pkg::batch_t head,
  output logic            pop,
  jsr_out_if.source       out_chan
);
  import jsr_pkg::*;

  logic [ItemIdxW-1:0] idx;
  logic                out_valid;
  item_t               out_item;
  logic                load;
  logic                at_end;

  assign load = !out_valid || out_chan.ready;
  assign at_end = (idx == head.count - ItemIdxW'(1));
  assign pop = load && !empty && at_end;

  assign out_chan.valid = out_valid;
  assign out_chan.out_byte = out_item.data;
  assign out_chan.out_last = out_item.last;
  assign out_chan.status = out_item.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) idx <= at_end ? '0 : idx + ItemIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) out_item <= head.items[idx];
  end

endmodule

// ===== src/jpeg_scan_restuffer_top.sv =====
// The restuffer takes one byte request per cycle while its two-batch queue
// has room; each request yields zero to six output bytes, which leave one
// per cycle through the output register while the output is ready. A result
// byte passes through the queue entry and then the output register.
//
// jpeg_scan_restuffer_top: front parser, batch queue and back serializer
// depends on jsr_pkg, jsr_in_if, jsr_out_if, jsr_front, jsr_queue, jsr_back
module jpeg_scan_restuffer_top (
  input  logic      clk,
  input  logic      rst,
  jsr_in_if.sink    in_chan,
  jsr_out_if.source out_chan
);
  import jsr_pkg::*;

  batch_t wr_batch;
  batch_t rd_batch;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  jsr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_chan),
    .full    (full),
    .push    (push),
    .batch   (wr_batch)
  );

  jsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_batch (wr_batch),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .rd_batch (rd_batch)
  );

  jsr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (rd_batch),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ===== tb/sv/jpeg_scan_restuffer_top_tb.sv =====
// jpeg_scan_restuffer_top_tb: self-checking bench for the jpeg scan restuffer
// feeds directed and random frames, predicts every output byte, compares in order
// depends on jsr_pkg, jsr_in_if, jsr_out_if and jpeg_scan_restuffer_top
module jpeg_scan_restuffer_top_tb;
  import jsr_pkg::*;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_REJECT = 1'b1;
  localparam int HoldBytes = 3;
  localparam int DrainCycles = 20;

  logic clk = 1'b0;
  logic rst;

  jsr_in_if in_chan();
  jsr_out_if out_chan();

  jpeg_scan_restuffer_top dut (
    .clk(clk),
    .rst(rst),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // restuffing predictor state
  logic [2:0]  parse_phase;
  logic [7:0]  held_bytes[HoldBytes];
  logic [1:0]  held_count;
  logic        lead_seen;
  logic [7:0]  len_hi;
  logic [15:0] hdr_remaining;
  logic        ff_pending;
  logic        drop_rest;
  int          step_count;

  item_t      expected_bytes[$];
  logic [7:0] frame_bytes[$];
  item_t      want;

  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  function automatic void clear_frame();
    parse_phase = PH_HOLD;
    foreach (held_bytes[i]) held_bytes[i] = BYTE_ZERO;
    held_count = 2'd0;
    lead_seen = 1'b0;
    len_hi = BYTE_ZERO;
    hdr_remaining = 16'd0;
    ff_pending = 1'b0;
    drop_rest = 1'b0;
  endfunction

  function automatic void push_out(logic [7:0] b, logic l, logic s);
    item_t it;
    if (step_count < MaxItems) begin
      it.data = b;
      it.last = l;
      it.status = s;
      expected_bytes = {expected_bytes, it};
      step_count++;
    end
  endfunction

  function automatic void append_byte(logic [7:0] v);
    frame_bytes = {frame_bytes, v};
  endfunction

  function automatic void close_with_eoi();
    push_out(BYTE_FF, 1'b0, ST_OK);
    push_out(BYTE_EOI, 1'b1, ST_OK);
    clear_frame();
  endfunction

  function automatic void entropy_step(logic [7:0] b, logic l);
    if (!ff_pending) begin
      if (b == BYTE_FF) begin
        if (l) begin
          push_out(BYTE_FF, 1'b0, ST_OK);
          push_out(BYTE_ZERO, 1'b0, ST_OK);
          close_with_eoi();
          return;
        end
        ff_pending = 1'b1;
      end else if (l && b == BYTE_EOI && lead_seen) begin
        close_with_eoi();
        return;
      end else begin
        push_out(b, 1'b0, ST_OK);
        if (l) begin
          close_with_eoi();
          return;
        end
      end
    end else if (b == BYTE_EOI) begin
      if (l) begin
        close_with_eoi();
        return;
      end
      push_out(BYTE_FF, 1'b0, ST_OK);
      push_out(BYTE_FF, 1'b0, ST_OK);
      push_out(BYTE_EOI, 1'b1, ST_OK);
      ff_pending = 1'b0;
      drop_rest = 1'b1;
    end else if (b == BYTE_ZERO || b[7:3] == RST_PREFIX) begin
      push_out(BYTE_FF, 1'b0, ST_OK);
      push_out(b, 1'b0, ST_OK);
      ff_pending = 1'b0;
      if (l) begin
        close_with_eoi();
        return;
      end
    end else if (b == BYTE_FF) begin
      push_out(BYTE_FF, 1'b0, ST_OK);
      push_out(BYTE_ZERO, 1'b0, ST_OK);
      if (l) begin
        push_out(BYTE_FF, 1'b0, ST_OK);
        push_out(BYTE_ZERO, 1'b0, ST_OK);
        close_with_eoi();
        return;
      end
    end else begin
      push_out(BYTE_FF, 1'b0, ST_OK);
      push_out(BYTE_ZERO, 1'b0, ST_OK);
      push_out(b, 1'b0, ST_OK);
      ff_pending = 1'b0;
      if (l) begin
        close_with_eoi();
        return;
      end
    end
    lead_seen = 1'b0;
  endfunction

  function automatic void scan_frame_byte(logic [7:0] b, logic l);
    logic [15:0] seg_len;
    case (parse_phase)
      PH_SCAN: begin
        push_out(b, l, ST_OK);
        if (lead_seen && b == BYTE_SOS) parse_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        push_out(b, l, ST_OK);
        len_hi = b;
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len = {len_hi, b};
        if (seg_len < 16'd2) begin
          push_out(b, 1'b0, ST_OK);
          parse_phase = PH_ENTROPY;
          lead_seen = 1'b0;
          if (l) close_with_eoi();
          return;
        end
        push_out(b, l, ST_OK);
        hdr_remaining = seg_len - 16'd2;
        parse_phase = (hdr_remaining != 16'd0) ? PH_REST : PH_ENTROPY;
      end
      PH_REST: begin
        push_out(b, l, ST_OK);
        hdr_remaining = hdr_remaining - 16'd1;
        if (hdr_remaining == 16'd0) parse_phase = PH_ENTROPY;
      end
      default: begin
        entropy_step(b, l);
        return;
      end
    endcase
    lead_seen = (b == BYTE_FF);
    if (l) clear_frame();
  endfunction

  function automatic void restuff_byte(logic [7:0] b, logic l);
    step_count = 0;
    if (drop_rest) begin
      if (l) clear_frame();
      return;
    end
    if (parse_phase == PH_REJECT) begin
      if (l) begin
        push_out(BYTE_ZERO, 1'b1, ST_REJECT);
        clear_frame();
      end
      return;
    end
    if (parse_phase == PH_HOLD) begin
      if (held_count < HoldBytes) begin
        if (l) begin
          push_out(BYTE_ZERO, 1'b1, ST_REJECT);
          clear_frame();
          return;
        end
        held_bytes[held_count] = b;
        held_count++;
        return;
      end
      if (held_bytes[0] != BYTE_FF || held_bytes[1] != BYTE_SOI) begin
        if (l) begin
          push_out(BYTE_ZERO, 1'b1, ST_REJECT);
          clear_frame();
        end else begin
          parse_phase = PH_REJECT;
        end
        return;
      end
      parse_phase = PH_SCAN;
      lead_seen = 1'b0;
      scan_frame_byte(held_bytes[0], 1'b0);
      scan_frame_byte(held_bytes[1], 1'b0);
      scan_frame_byte(held_bytes[2], 1'b0);
      scan_frame_byte(b, l);
      return;
    end
    scan_frame_byte(b, l);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_v);
    if (mismatch_count < 100)
      $display("mismatch %s: got %02h want %02h at %0t", what, got, exp_v, $time);
    mismatch_count++;
  endtask

  // output side: ready pattern and long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", out_chan.out_byte, BYTE_ZERO);
      end else begin
        want = expected_bytes.pop_front();
        if (out_chan.out_byte !== want.data)
          report_mismatch("out_byte", out_chan.out_byte, want.data);
        if (out_chan.out_last !== want.last)
          report_mismatch("out_last", {7'd0, out_chan.out_last}, {7'd0, want.last});
        if (out_chan.status !== want.status)
          report_mismatch("status", {7'd0, out_chan.status}, {7'd0, want.status});
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.in_byte <= b;
    in_chan.in_last <= l;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    restuff_byte(b, l);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic test_short_frame();
    frame_bytes = '{8'h80};
    send_frame();
  endtask

  task automatic test_bad_start_marker();
    frame_bytes = '{BYTE_FF, BYTE_EOI, 8'h00, BYTE_FF};
    send_frame();
  endtask

  task automatic test_no_scan_passthrough();
    frame_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, 8'h00};
    send_frame();
  endtask

  // zero scan length, stuffed pairs, restart markers, lone leads, early end
  task automatic test_short_scan_length();
    frame_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOS, 8'h00, 8'h00,
                    BYTE_FF, 8'h00, BYTE_FF, 8'hD7, BYTE_FF, BYTE_FF, 8'h01,
                    BYTE_FF, BYTE_EOI, 8'h55, BYTE_FF};
    send_frame();
  endtask

  task automatic test_header_lead_then_eoi();
    frame_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOS, 8'h00, 8'h03,
                    BYTE_FF, BYTE_EOI};
    send_frame();
  endtask

  task automatic test_trailing_lead();
    frame_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOS, 8'h00, 8'h02,
                    8'hD0, BYTE_FF};
    send_frame();
  endtask

  task automatic build_random_frame();
    int kind;
    int n;
    int pick;
    int seg_len;
    frame_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(1, 3);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 18) begin
      n = $urandom_range(4, 8);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    append_byte(BYTE_FF);
    append_byte(BYTE_SOI);
    n = $urandom_range(0, 3);
    repeat (n) append_byte(8'($urandom_range(0, 255)));
    if (kind < 24) begin
      n = $urandom_range(0, 3);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    append_byte(BYTE_FF);
    append_byte(BYTE_SOS);
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      append_byte(BYTE_ZERO);
      append_byte(8'(pick));
    end else if (pick < 4) begin
      // big length, frame cut inside the header
      n = $urandom_range(2, 6);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
      return;
    end else begin
      seg_len = $urandom_range(2, 6);
      append_byte(BYTE_ZERO);
      append_byte(8'(seg_len));
      repeat (seg_len - 2) append_byte(8'($urandom_range(0, 255)));
    end
    n = $urandom_range(1, 10);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        append_byte(8'($urandom_range(0, 255)));
      end else begin
        append_byte(BYTE_FF);
        case (pick)
          12, 13: append_byte(BYTE_ZERO);
          14, 15: append_byte(8'hD0 + 8'($urandom_range(0, 7)));
          16: append_byte(BYTE_FF);
          17: append_byte(BYTE_EOI);
          default: append_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      append_byte(BYTE_FF);
      append_byte(BYTE_EOI);
    end else if (pick < 8) begin
      append_byte(8'($urandom_range(0, 255)));
    end else begin
      append_byte(BYTE_FF);
    end
  endtask

  task automatic test_random_frames(input int count, input int idle_v, input int stall_v);
    int sent;
    sent = 0;
    idle_pct = idle_v;
    stall_pct = stall_v;
    while (sent < count) begin
      build_random_frame();
      send_frame();
      sent += frame_bytes.size();
    end
  endtask

  // long output hold-off while requests keep coming
  task automatic test_backpressure();
    int sent;
    sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    while (sent < 30) begin
      build_random_frame();
      send_frame();
      sent += frame_bytes.size();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_chan.valid = 1'b0;
    in_chan.in_byte = BYTE_ZERO;
    in_chan.in_last = 1'b0;
    out_chan.ready = 1'b0;
    clear_frame();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_short_frame();
    test_bad_start_marker();
    test_no_scan_passthrough();
    test_short_scan_length();
    test_header_lead_then_eoi();
    test_trailing_lead();
    test_random_frames(50, 0, 0);
    test_random_frames(50, 81, 0);
    test_random_frames(50, 0, 81);
    test_random_frames(50, 10, 10);
    test_backpressure();

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0)
      $display("PASS jpeg_scan_restuffer_top");
    else
      $display("FAIL jpeg_scan_restuffer_top");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL jpeg_scan_restuffer_top");
    $finish;
  end

endmodule

// ===== sim.f =====
src/jsr_pkg.sv
src/jsr_in_if.sv
src/jsr_out_if.sv
src/jsr_front.sv
src/jsr_queue.sv
src/jsr_back.sv
src/jpeg_scan_restuffer_top.sv
tb/sv/jpeg_scan_restuffer_top_tb.sv
